@@ hdl/tpim_pkg.sv @@
`timescale 1ns / 1ps
package tpim_pkg;
  localparam int RANK       = 4;
  localparam int IDX_W      = 24;
  localparam int DIM_W      = 13;
  localparam int AX_W       = 2;
  localparam int AXIS_W     = RANK * AX_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = DIM_W;
  localparam int CNT_W      = RANK * DIM_W;
  localparam int NUM_DIV    = RANK - 1;
  localparam int DIV_STEPS  = IDX_W;
  localparam int PIPE_LEN   = DIV_STEPS * NUM_DIV;

  localparam logic [DIM_W-1:0]  DIM_RESET  = DIM_W'(1);
  localparam logic [AXIS_W-1:0] AXIS_RESET = AXIS_W'(228);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIM0,
    REG_DIM1,
    REG_DIM2,
    REG_DIM3,
    REG_AXIS
  } cfg_reg_t;

  typedef struct packed {
    logic             valid;
    logic             flag;
    logic [IDX_W-1:0] x;
    logic [DIM_W-1:0] r;
    logic [DIM_W-1:0] c3;
    logic [DIM_W-1:0] c2;
  } div_stage_t;
endpackage

@@ hdl/tpim_if.sv @@
`timescale 1ns / 1ps
interface tpim_in_if import tpim_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] perm_index;
  modport source(output valid, output perm_index, input ready);
  modport sink(input valid, input perm_index, output ready);
endinterface

interface tpim_out_if import tpim_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] source_index;
  logic             out_of_range;
  modport source(output valid, output source_index, output out_of_range, input ready);
  modport sink(input valid, input source_index, input out_of_range, output ready);
endinterface

@@ hdl/tensor_permute_index_map_unit.sv @@
`timescale 1ns / 1ps
// Tensor permute address generator.
// in_ch carries perm_index, a row-major position in the permuted tensor;
// out_ch returns source_index and out_of_range, one word per input word.
// Configuration: cfg_we/cfg_index/cfg_data write dim_size_0..3 (index 0..3)
// and axis_order (index 4); other indexes are ignored. Derived sizes,
// strides and counts settle through the derived-shape registers after a write.
// Throughput: one word per cycle while out_ch is not stalled. From accept to
// out_ch valid: 74 register stages, the first loaded at the accept edge,
// made of three 24-step restoring dividers (one quotient bit per stage,
// divisors are the output dimension sizes), a multiply stage and the output
// register.
// A stall on out_ch freezes the whole pipeline; in_ch.ready drops in the
// same cycle, so nothing is lost or repeated.
// Reset (rst, synchronous) empties the pipeline and loads all sizes with 1
// and the identity axis order.
module tensor_permute_index_map_unit import tpim_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  tpim_in_if.sink               in_ch,
  tpim_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  localparam logic [CNT_W-1:0] SPAN = CNT_W'(1) << IDX_W;

  logic [DIM_W-1:0]  dim_size [RANK];
  logic [AXIS_W-1:0] axis_order;
  logic [DIM_W-1:0]  out_size [RANK];

  logic [2*DIM_W-1:0]       p01, p23, o01, o23;
  logic [CNT_W-1:0]         src_count, out_count;
  logic [IDX_W-1:0]         s0;
  logic                     cfg_big;
  logic [IDX_W-1:0]         stride [RANK];
  logic [IDX_W+DIM_W-1:0]   s0_full;

  div_stage_t pipe [PIPE_LEN];
  div_stage_t head;

  logic             adv;
  logic             mv, mflag;
  logic [IDX_W-1:0] m [RANK];
  logic [IDX_W-1:0] c [RANK];
  logic             ov, oflag;
  logic [IDX_W-1:0] osum;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RANK; i++) dim_size[i] <= DIM_RESET;
      axis_order <= AXIS_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DIM0: dim_size[0] <= cfg_data;
        REG_DIM1: dim_size[1] <= cfg_data;
        REG_DIM2: dim_size[2] <= cfg_data;
        REG_DIM3: dim_size[3] <= cfg_data;
        REG_AXIS: axis_order  <= cfg_data[AXIS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int d = 0; d < RANK; d++) out_size[d] = dim_size[axis_order[AX_W*d +: AX_W]];
  end

  assign s0_full = p23[IDX_W-1:0] * dim_size[1];

  // derived shape values, three register levels
  always_ff @(posedge clk) begin
    p01       <= dim_size[0] * dim_size[1];
    p23       <= dim_size[2] * dim_size[3];
    o01       <= out_size[0] * out_size[1];
    o23       <= out_size[2] * out_size[3];
    src_count <= p01 * p23;
    out_count <= o01 * o23;
    s0        <= s0_full[IDX_W-1:0];
    cfg_big   <= (src_count > SPAN) || (out_count > SPAN);
  end

  always_comb begin
    stride[0] = s0;
    stride[1] = p23[IDX_W-1:0];
    stride[2] = IDX_W'(dim_size[3]);
    stride[3] = IDX_W'(1);
  end

  assign adv         = !ov || out_ch.ready;
  assign in_ch.ready = adv;

  always_comb begin
    head.valid = in_ch.valid;
    head.flag  = cfg_big || (CNT_W'(in_ch.perm_index) >= out_count);
    head.x     = in_ch.perm_index;
    head.r     = '0;
    head.c3    = '0;
    head.c2    = '0;
  end

  // one quotient bit per stage; divider k divides by out_size[RANK-1-k]
  for (genvar j = 0; j < PIPE_LEN; j++) begin : g_div
    localparam int K = j / DIV_STEPS;
    div_stage_t       s_in, s_out;
    logic [DIM_W:0]   t;
    logic [DIM_W-1:0] dv;
    logic             q;

    if (j == 0) begin : g_first
      assign s_in = head;
    end else if ((j % DIV_STEPS) == 0) begin : g_bound
      always_comb begin
        s_in   = pipe[j-1];
        s_in.r = '0;
        if (K == 1) s_in.c3 = pipe[j-1].r;
        else        s_in.c2 = pipe[j-1].r;
      end
    end else begin : g_mid
      assign s_in = pipe[j-1];
    end

    assign dv = out_size[RANK-1-K];

    always_comb begin
      t     = {s_in.r, s_in.x[IDX_W-1]};
      s_out = s_in;
      q     = 1'b0;
      if (t >= {1'b0, dv}) begin
        q       = 1'b1;
        s_out.r = DIM_W'(t - {1'b0, dv});
      end else begin
        s_out.r = t[DIM_W-1:0];
      end
      s_out.x = {s_in.x[IDX_W-2:0], q};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pipe[j].valid <= 1'b0;
      end else if (adv) begin
        pipe[j] <= s_out;
      end
    end
  end

  always_comb begin
    c[0] = pipe[PIPE_LEN-1].x;
    c[1] = IDX_W'(pipe[PIPE_LEN-1].r);
    c[2] = IDX_W'(pipe[PIPE_LEN-1].c2);
    c[3] = IDX_W'(pipe[PIPE_LEN-1].c3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
      ov <= 1'b0;
    end else if (adv) begin
      mv    <= pipe[PIPE_LEN-1].valid;
      mflag <= pipe[PIPE_LEN-1].flag;
      for (int d = 0; d < RANK; d++) begin
        m[d] <= IDX_W'(c[d] * stride[axis_order[AX_W*d +: AX_W]]);
      end
      ov    <= mv;
      oflag <= mflag;
      osum  <= mflag ? '0 : IDX_W'(m[0] + m[1] + m[2] + m[3]);
    end
  end

  assign out_ch.valid        = ov;
  assign out_ch.source_index = osum;
  assign out_ch.out_of_range = oflag;
endmodule

@@ hdl/tpim_checker.sv @@
`timescale 1ns / 1ps
module tpim_checker import tpim_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [IDX_W-1:0] source_index,
  input logic             out_of_range
);
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> source_index == '0)
    else $error("flagged word carries nonzero index");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(source_index) && $stable(out_of_range))
    else $error("stalled output changed");
endmodule

bind tensor_permute_index_map_unit tpim_checker u_tpim_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .source_index (out_ch.source_index),
  .out_of_range (out_ch.out_of_range)
);

@@ tb/tensor_permute_index_map_unit_tb.sv @@
`timescale 1ns / 1ps
module tensor_permute_index_map_unit_tb;
  import tpim_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = CFG_IDX_W'(REG_AXIS) + 1'b1;
  localparam longint unsigned INDEX_SPAN = 64'd1 << IDX_W;
  localparam logic [IDX_W-1:0] INDEX_TOP = {IDX_W{1'b1}};
  localparam int DRAIN_CYCLES = 120;

  typedef struct {
    logic [IDX_W-1:0] source_index;
    logic             out_of_range;
  } addr_word_t;

  class tensor_addr_book;
    logic [DIM_W-1:0]  dim_size [RANK];
    logic [AXIS_W-1:0] axis_order;
    addr_word_t        pending [$];
    int                errors;

    function new();
      foreach (dim_size[i]) dim_size[i] = DIM_RESET;
      axis_order = AXIS_RESET;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx < RANK) dim_size[idx] = data;
      else if (idx == REG_AXIS) axis_order = data[AXIS_W-1:0];
    endfunction

    function int unsigned axis_of(int d);
      return axis_order[2*d +: 2];
    endfunction

    function longint unsigned out_count();
      longint unsigned n;
      n = 1;
      for (int d = 0; d < RANK; d++) n = n * dim_size[axis_of(d)];
      return n;
    endfunction

    function addr_word_t map_address(logic [IDX_W-1:0] idx);
      longint unsigned src_stride [RANK];
      longint unsigned out_stride [RANK];
      longint unsigned src_count, cnt, rem, sum, coord;
      addr_word_t w;
      src_count = 1;
      for (int d = 0; d < RANK; d++) src_count = src_count * dim_size[d];
      src_stride[RANK-1] = 1;
      out_stride[RANK-1] = 1;
      for (int d = RANK - 2; d >= 0; d--) begin
        src_stride[d] = src_stride[d+1] * dim_size[d+1];
        out_stride[d] = out_stride[d+1] * dim_size[axis_of(d+1)];
      end
      cnt = out_count();
      w.out_of_range = (idx >= cnt) || (cnt > INDEX_SPAN) || (src_count > INDEX_SPAN);
      sum = 0;
      if (!w.out_of_range) begin
        rem = idx;
        for (int d = 0; d < RANK; d++) begin
          coord = rem / out_stride[d];
          rem = rem % out_stride[d];
          sum = sum + coord * src_stride[axis_of(d)];
        end
      end
      w.source_index = w.out_of_range ? '0 : sum[IDX_W-1:0];
      return w;
    endfunction

    function void note_index(logic [IDX_W-1:0] idx);
      pending.insert(pending.size(), map_address(idx));
    endfunction

    function void report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endfunction

    function void check_word(logic [IDX_W-1:0] src, logic oor);
      addr_word_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word src=%0d oor=%0b", src, oor));
        return;
      end
      e = pending.pop_front();
      if (src !== e.source_index)
        report($sformatf("source_index %0d, want %0d", src, e.source_index));
      if (oor !== e.out_of_range)
        report($sformatf("out_of_range %0b, want %0b", oor, e.out_of_range));
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tpim_in_if  in_ch();
  tpim_out_if out_ch();

  tensor_permute_index_map_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tensor_addr_book book = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold = 0;
  bit run_done = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("FAIL");
    $finish;
  end

  // receiver: random stalls, long hold-off on request, check each word
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        book.check_word(out_ch.source_index, out_ch.out_of_range);
      if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic push_index(input logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.perm_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    book.note_index(idx);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (book.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    book.set_reg(idx, data);
  endtask

  task automatic set_shape(input int d0, d1, d2, d3, input int ax);
    write_reg(REG_DIM0, CFG_DATA_W'(d0));
    write_reg(REG_DIM1, CFG_DATA_W'(d1));
    write_reg(REG_DIM2, CFG_DATA_W'(d2));
    write_reg(REG_DIM3, CFG_DATA_W'(d3));
    write_reg(REG_AXIS, CFG_DATA_W'(ax));
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [IDX_W-1:0] pick_index();
    longint unsigned cnt;
    cnt = book.out_count();
    if (cnt > 0 && cnt <= INDEX_SPAN && $urandom_range(99) < 85) begin
      if ($urandom_range(9) == 0) return IDX_W'(cnt - 1);
      return IDX_W'({$urandom(), $urandom()} % cnt);
    end
    return IDX_W'($urandom());
  endfunction

  function automatic int pick_dim();
    int r;
    r = $urandom_range(99);
    if (r < 3) return 0;
    if (r < 6) return 4096;
    if (r < 8) return 8191;
    if (r < 30) return 1;
    return $urandom_range(1, 20);
  endfunction

  task automatic random_burst(input int n, input bit mid_pause);
    for (int i = 0; i < n; i++) begin
      if (mid_pause && i == n / 2) wait_drained();
      push_index(pick_index());
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.perm_index <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (4) @(posedge clk);

    // directed: reset shape, then special shapes
    push_index('0);
    push_index(IDX_W'(1));
    push_index(INDEX_TOP);
    wait_drained();

    set_shape(2, 3, 4, 5, 8'h1B);
    push_index('0);
    push_index(IDX_W'(57));
    push_index(IDX_W'(119));
    push_index(IDX_W'(120));
    wait_drained();

    set_shape(4096, 4096, 1, 1, 8'hE1);
    push_index(INDEX_TOP);
    push_index(IDX_W'(4097));
    push_index('0);
    wait_drained();

    set_shape(4096, 4096, 2, 1, 8'hE4);
    push_index('0);
    wait_drained();

    set_shape(3, 0, 4, 5, 8'h9C);
    push_index('0);
    push_index(IDX_W'(7));
    wait_drained();

    set_shape(8191, 2, 1, 1, 8'hE4);
    push_index(IDX_W'(5));
    wait_drained();

    set_shape(60, 2, 2, 2, 8'h00);
    push_index(IDX_W'(12959999));
    push_index(IDX_W'(12960000));
    push_index(IDX_W'(123457));
    wait_drained();

    set_shape(5, 6, 7, 3, 8'hFF);
    push_index(IDX_W'(26));
    push_index(IDX_W'(9));
    wait_drained();

    // writes to unused indexes must leave the shape alone
    for (int i = REG_FIRST_UNUSED; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), '1);
    repeat (4) @(posedge clk);
    push_index(IDX_W'(100));
    push_index(IDX_W'(3));
    wait_drained();

    for (int ph = 0; ph < 12; ph++) begin
      if (ph < 4) begin
        tx_idle_pct = 21; rx_idle_pct = 87;
      end else if (ph < 8) begin
        tx_idle_pct = 87; rx_idle_pct = 21;
      end else begin
        tx_idle_pct = 0; rx_idle_pct = 0;
      end
      if (ph == 0) set_shape(1, 1, 1, 1, 8'hE4);
      else if (ph == 9) set_shape(4096, 4096, 1, 1, 8'h4E);
      else if (ph == 5) set_shape(8191, 8191, 8191, 8191, 8'hFF);
      else set_shape(pick_dim(), pick_dim(), pick_dim(), pick_dim(), $urandom_range(255));
      if (ph == 10) rx_hold = 300;
      random_burst(78, ph == 6 || ph == 10);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.pending.size() != 0)
      book.report($sformatf("%0d words never came", book.pending.size()));
    if (book.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
